FILE: rtl/hcs_pkg.sv
`default_nettype none

package hcs_pkg;

    // Largest graph the block holds; the row and vertex widths follow the port widths.
    localparam int MAX_VERTICES = 16;
    localparam int ROW_W        = 16;
    localparam int VERTEX_W     = 4;
    localparam int COUNT_W      = 5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // store one adjacency row
        logic step;  // one depth-first move: extend the path or retreat
        logic emit;  // drive the top of the path and pop it
        logic fail;  // drive the single no-cycle word
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_row;   // the row being loaded completes the graph
        logic found_now;  // the path is full and closes back to vertex 0
        logic fail_now;   // nothing left to try at the root
        logic emit_last;  // the next word to emit is vertex 0
    } t_status;

    // Number of vertices in use: zero acts as one, large values are clipped.
    function automatic logic [COUNT_W-1:0] f_eff_count(input logic [COUNT_W-1:0] vc);
        logic [COUNT_W-1:0] n;
        begin
            n = vc;
            if (vc == '0) begin
                n = COUNT_W'(1);
            end else if (vc > COUNT_W'(MAX_VERTICES)) begin
                n = COUNT_W'(MAX_VERTICES);
            end
            return n;
        end
    endfunction

    // Index of the lowest set bit (zero when no bit is set).
    function automatic logic [VERTEX_W-1:0] f_low_index(input logic [ROW_W-1:0] x);
        logic [ROW_W-1:0]    lb;
        logic [VERTEX_W-1:0] idx;
        begin
            lb  = x & (~x + ROW_W'(1));
            idx = '0;
            for (int j = 0; j < ROW_W; j++) begin
                if (lb[j]) begin
                    idx = idx | VERTEX_W'(j);
                end
            end
            return idx;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hcs_dp.sv
`default_nettype none

module hcs_dp
    import hcs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire logic [ROW_W-1:0]    i_row_bits,
    input  wire logic [COUNT_W-1:0]  i_count,
    output t_status                  o_status,
    output logic                     o_valid,
    output logic [VERTEX_W-1:0]      o_vertex,
    output logic                     o_found,
    output logic                     o_last
);

    logic [ROW_W-1:0]    r_adj  [MAX_VERTICES];
    logic [VERTEX_W-1:0] r_path [MAX_VERTICES];
    logic [COUNT_W-1:0]  r_cand [MAX_VERTICES];
    logic [COUNT_W-1:0]  r_rows;
    logic [VERTEX_W-1:0] r_depth;
    logic [ROW_W-1:0]    r_unvis;
    logic                r_valid;
    logic [VERTEX_W-1:0] r_vertex;
    logic                r_found;
    logic                r_last;

    logic [VERTEX_W-1:0] top;
    logic [ROW_W-1:0]    adj_top;
    logic [COUNT_W-1:0]  cand_cur;
    logic [ROW_W:0]      ge_mask;
    logic [ROW_W:0]      used_mask;
    logic                at_full;
    logic [ROW_W-1:0]    avail;
    logic [VERTEX_W-1:0] pick;
    logic [COUNT_W-1:0]  n_rows;

    assign top       = r_path[r_depth];
    assign adj_top   = r_adj[top];
    assign cand_cur  = r_cand[r_depth];
    // Candidates at or above the stored resume point.
    assign ge_mask   = ~(((ROW_W+1)'(1) << cand_cur) - (ROW_W+1)'(1));
    assign used_mask = ((ROW_W+1)'(1) << i_count) - (ROW_W+1)'(1);
    assign at_full   = ({1'b0, r_depth} == (i_count - COUNT_W'(1)));
    assign avail     = at_full ? '0 : (adj_top & r_unvis & ge_mask[ROW_W-1:0]);
    assign pick      = f_low_index(avail);
    assign n_rows    = r_rows + COUNT_W'(1);

    always_comb begin
        o_status.last_row  = (n_rows >= i_count);
        o_status.found_now = at_full & adj_top[0];
        o_status.fail_now  = ~(at_full & adj_top[0]) & (avail == '0) & (r_depth == '0);
        o_status.emit_last = (r_depth == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit | i_cmd.fail;
            if (i_cmd.load) begin
                r_rows <= o_status.last_row ? '0 : n_rows;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_adj[r_rows[VERTEX_W-1:0]] <= i_row_bits;
            if (o_status.last_row) begin
                r_depth   <= '0;
                r_path[0] <= '0;
                r_cand[0] <= COUNT_W'(1);
                r_unvis   <= used_mask[ROW_W-1:0] & ~ROW_W'(1);
            end
        end
        if (i_cmd.step) begin
            if (avail != '0) begin
                r_cand[r_depth]                 <= {1'b0, pick} + COUNT_W'(1);
                r_path[r_depth + VERTEX_W'(1)]  <= pick;
                r_cand[r_depth + VERTEX_W'(1)]  <= COUNT_W'(1);
                r_depth                         <= r_depth + VERTEX_W'(1);
                r_unvis[pick]                   <= 1'b0;
            end else begin
                r_unvis[top] <= 1'b1;
                r_depth      <= r_depth - VERTEX_W'(1);
            end
        end
        if (i_cmd.emit) begin
            r_vertex <= top;
            r_found  <= 1'b1;
            r_last   <= o_status.emit_last;
            r_depth  <= r_depth - VERTEX_W'(1);
        end
        if (i_cmd.fail) begin
            r_vertex <= '0;
            r_found  <= 1'b0;
            r_last   <= 1'b1;
        end
    end

    assign o_valid  = r_valid;
    assign o_vertex = r_vertex;
    assign o_found  = r_found;
    assign o_last   = r_last;

endmodule

`default_nettype wire

FILE: rtl/hcs_ctrl.sv
`default_nettype none

module hcs_ctrl
    import hcs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_EMIT   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_status.last_row) begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (i_status.found_now) begin
                    n_state = S_EMIT;
                end else if (i_status.fail_now) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/hamiltonian_cycle_search.sv
// Hamiltonian cycle search. Load the graph as one adjacency row per word on
// i_row_bits (row r is the r-th word since reset or since the previous search),
// one word per cycle while busy is low. The word that completes vertex_count
// rows starts a depth-first backtracking search from vertex 0 that tries
// successors in ascending order; busy stays high until the run's last result.
// The search makes one move per cycle (extend the path by one vertex, or retreat
// by one); the number of moves is what the graph demands, from none at all when
// vertex 0 has no successors, n-1 for a cycle found without backtracking, up to
// exponential in n, and a closing check follows the last move. A found cycle is
// then delivered as n words, one per cycle, deepest vertex first and vertex 0 last
// with o_last set; when there is no cycle a single word with o_found clear and
// o_last set is delivered. Each result word is shown for exactly one cycle on
// o_valid and the receiver cannot stall it, so it must capture every strobe.
`default_nettype none

module hamiltonian_cycle_search
    import hcs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Command channel: a word is taken when start is high and busy is low.
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [ROW_W-1:0]    i_row_bits,
    // Result words, one cycle each.
    output logic                     o_valid,
    output logic [VERTEX_W-1:0]      o_vertex,
    output logic                     o_found,
    output logic                     o_last,
    // Register port; vertex_count lies at byte address 0.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic [COUNT_W-1:0] r_vertex_count;
    logic [COUNT_W-1:0] eff_count;
    logic               reg_write;
    t_cmd               cmd;
    t_status            status;

    // Register block. Only the word at index zero holds anything; writes to the
    // other index are accepted and dropped.
    assign pready    = 1'b1;
    assign reg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= COUNT_W'(MAX_VERTICES);
        end else if (reg_write && (paddr[2] == 1'b0)) begin
            r_vertex_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32-COUNT_W){1'b0}}, r_vertex_count} : '0;

    // A count of zero behaves as a single vertex and anything above the array
    // size is clipped to it.
    assign eff_count = f_eff_count(r_vertex_count);

    // The controller sequences loading, searching and delivery; the datapath
    // holds the graph, the path stack with its resume points and the visited set.
    hcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    hcs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_row_bits (i_row_bits),
        .i_count    (eff_count),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_vertex   (o_vertex),
        .o_found    (o_found),
        .o_last     (o_last)
    );

    // Every result word comes out of a cycle in which the search was running.
    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result word without a running search");

    // The no-cycle answer is one word: vertex 0, marked last.
    a_none_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_last && (o_vertex == '0)))
        else $error("malformed no-cycle word");

    // A found cycle always ends on the start vertex.
    a_cycle_ends_at_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found && o_last) |-> (o_vertex == '0))
        else $error("cycle does not end at vertex 0");

    // A new run must load and search before it delivers, so the last word stands alone.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("word follows the last word of a run");

endmodule

`default_nettype wire
